// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, suspended while arst_n is low.
`define MSVD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MSVD_ASSERT_IMP(lbl, ante, cons, msg) \
	`MSVD_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MSVD_ASSERT_NXT(lbl, ante, cons, msg) \
	`MSVD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/core/msvd_pkg.sv
`default_nettype none

package msvd_pkg;

	localparam int MAX_LEVELS = 8;
	localparam int EXT_W      = 16;
	localparam int STRIDE_W   = EXT_W + 1;
	localparam int LEVEL_W    = 4;
	localparam int LVL_IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int SPL_W      = 3;
	localparam int RATE_W     = 5;
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [STRIDE_W-1:0] STRIDE_ONE = STRIDE_W'(1);
	localparam logic [STRIDE_W-1:0] STRIDE_CAP = {1'b1, {EXT_W{1'b0}}};

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_EXT_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPLITS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd5;

	// Effective configuration: level count clamped, rate at least two.
	typedef struct packed {
		logic [EXT_W-1:0]   ext_x;
		logic [EXT_W-1:0]   ext_y;
		logic [EXT_W-1:0]   ext_z;
		logic [LEVEL_W-1:0] levels;
		logic [SPL_W-1:0]   splits;
		logic [RATE_W-1:0]  rate;
	} cfg_t;

	// One queued sample word and the set of levels that keep it.
	typedef struct packed {
		logic [WORD_W-1:0]     word;
		logic [MAX_LEVELS-1:0] mask;
	} q_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/msvd_cdiv.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, result rounded up.
module msvd_cdiv (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [msvd_pkg::EXT_W-1:0]   dividend,
	input  wire logic [msvd_pkg::RATE_W-1:0]  divisor,
	output logic                              done,
	output logic [msvd_pkg::EXT_W-1:0]        quot
);
	import msvd_pkg::*;

	localparam int CNT_W = $clog2(EXT_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [EXT_W-1:0]   dvd_q;
	logic [EXT_W-1:0]   quot_q;
	logic [RATE_W-1:0]  rem_q;
	logic [RATE_W:0]    rem_sh;
	logic [RATE_W:0]    rem_sub;
	logic               ge;

	assign rem_sh  = {rem_q, dvd_q[EXT_W-1]};
	assign ge      = rem_sh >= {1'b0, divisor};
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(EXT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[EXT_W-2:0], 1'b0};
			rem_q  <= ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
			quot_q <= {quot_q[EXT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q + EXT_W'(rem_q != '0);

endmodule

`default_nettype wire

// File: rtl/core/msvd_fifo.sv
`default_nettype none

module msvd_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire msvd_pkg::q_entry_t  push_entry,
	output logic                     full,
	input  wire logic                pop,
	output msvd_pkg::q_entry_t       head,
	output logic                     empty
);
	import msvd_pkg::*;

	q_entry_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/msvd_back.sv
`default_nettype none

// Expands one queued word into a result per kept level, lowest level first.
module msvd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire msvd_pkg::q_entry_t            q_head,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [msvd_pkg::WORD_W-1:0]        sample_out,
	output logic [msvd_pkg::LEVEL_W-1:0]       level_index,
	output logic                               last_of_run
);
	import msvd_pkg::*;

	logic                   cur_valid_q;
	logic [WORD_W-1:0]      cur_word_q;
	logic [MAX_LEVELS-1:0]  cur_mask_q;
	logic                   out_valid_q;
	logic [WORD_W-1:0]      sample_q;
	logic [LEVEL_W-1:0]     level_q;
	logic                   last_q;

	logic                   emit;
	logic [MAX_LEVELS-1:0]  rest;
	logic [LEVEL_W-1:0]     low_idx;

	assign emit = cur_valid_q && (!out_valid_q || out_ready);
	assign rest = cur_mask_q & (cur_mask_q - MAX_LEVELS'(1));
	assign pop  = !q_empty && (!cur_valid_q || (emit && rest == '0));

	always_comb begin
		low_idx = '0;
		for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
			if (cur_mask_q[l]) begin
				low_idx = LEVEL_W'(l);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (emit && rest == '0) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_word_q <= q_head.word;
			cur_mask_q <= q_head.mask;
		end else if (emit) begin
			cur_mask_q <= rest;
		end
		if (emit) begin
			sample_q <= cur_word_q;
			level_q  <= low_idx + LEVEL_W'(1);
			last_q   <= rest == '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_q;
	assign level_index = level_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

// File: rtl/core/msvd_front.sv
`default_nettype none

// Accepts samples, derives the per-level strides at volume start, tracks the
// position of each sample and classifies it into the levels that keep it.
module msvd_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire msvd_pkg::cfg_t              cfg,
	input  wire logic                        restart,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [msvd_pkg::WORD_W-1:0] sample_bits,
	output logic                             push,
	output msvd_pkg::q_entry_t               push_entry,
	input  wire logic                        q_full,
	output logic                             busy
);
	import msvd_pkg::*;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_LEVEL = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;

	logic [1:0]             state_q;
	logic                   strides_ready_q;
	logic [LEVEL_W-1:0]     lv_q;
	logic [SPL_W-1:0]       d_q;
	logic [1:0]             axis_q;
	logic [EXT_W-1:0]       wext_q [3];
	logic [STRIDE_W-1:0]    strd_q [3];
	logic [STRIDE_W-1:0]    tx_q [MAX_LEVELS];
	logic [STRIDE_W-1:0]    ty_q [MAX_LEVELS];
	logic [STRIDE_W-1:0]    tz_q [MAX_LEVELS];

	logic [EXT_W-1:0]       ci_q, cj_q, ck_q;
	logic [STRIDE_W-1:0]    rx_q [MAX_LEVELS];
	logic [STRIDE_W-1:0]    ry_q [MAX_LEVELS];
	logic [STRIDE_W-1:0]    rz_q [MAX_LEVELS];

	logic [1:0]                    axis_pick;
	logic [STRIDE_W+RATE_W-1:0]    prod;
	logic [STRIDE_W-1:0]           grown;
	logic                          div_start;
	logic                          div_done;
	logic [EXT_W-1:0]              div_quot;
	logic                          derive_go;
	logic                          fire;
	logic [MAX_LEVELS-1:0]         mask;
	logic [EXT_W-1:0]              i_inc, j_inc, k_inc;
	logic                          wrap_x, wrap_y, wrap_z;
	logic [STRIDE_W-1:0]           rx_adv [MAX_LEVELS];
	logic [STRIDE_W-1:0]           ry_adv [MAX_LEVELS];
	logic [STRIDE_W-1:0]           rz_adv [MAX_LEVELS];

	// The largest working extent is split next; ties go z, then y, then x.
	always_comb begin
		if (wext_q[2] >= wext_q[1] && wext_q[2] >= wext_q[0]) begin
			axis_pick = 2'd2;
		end else if (wext_q[1] >= wext_q[0]) begin
			axis_pick = 2'd1;
		end else begin
			axis_pick = 2'd0;
		end
	end

	assign prod  = strd_q[axis_pick] * cfg.rate;
	assign grown = (prod > (STRIDE_W + RATE_W)'(STRIDE_CAP)) ? STRIDE_CAP
		: prod[STRIDE_W-1:0];

	assign div_start = (state_q == ST_LEVEL) && (d_q != cfg.splits);
	assign derive_go = (state_q == ST_RUN) && !strides_ready_q && in_valid && !restart;

	msvd_cdiv u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wext_q[axis_pick]),
		.divisor  (cfg.rate),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign busy     = state_q != ST_RUN;
	assign in_ready = (state_q == ST_RUN) && strides_ready_q && !q_full;
	assign fire     = in_valid && in_ready;

	always_comb begin
		for (int l = 0; l < MAX_LEVELS; l++) begin
			mask[l] = (LEVEL_W'(l) < cfg.levels) && rx_q[l] == '0 && ry_q[l] == '0
				&& rz_q[l] == '0;
		end
	end

	assign push             = fire && (mask != '0);
	assign push_entry.word  = sample_bits;
	assign push_entry.mask  = mask;

	// Position advance, x fastest.
	assign i_inc  = ci_q + EXT_W'(1);
	assign j_inc  = cj_q + EXT_W'(1);
	assign k_inc  = ck_q + EXT_W'(1);
	assign wrap_x = i_inc == cfg.ext_x;
	assign wrap_y = wrap_x && (j_inc == cfg.ext_y);
	assign wrap_z = wrap_y && (k_inc == cfg.ext_z);

	// Each residue is the coordinate modulo that level's stride.
	always_comb begin
		for (int l = 0; l < MAX_LEVELS; l++) begin
			rx_adv[l] = (rx_q[l] + STRIDE_ONE == tx_q[l]) ? '0 : rx_q[l] + STRIDE_ONE;
			ry_adv[l] = (ry_q[l] + STRIDE_ONE == ty_q[l]) ? '0 : ry_q[l] + STRIDE_ONE;
			rz_adv[l] = (rz_q[l] + STRIDE_ONE == tz_q[l]) ? '0 : rz_q[l] + STRIDE_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_RUN;
			strides_ready_q <= 1'b0;
			lv_q            <= '0;
			d_q             <= '0;
			axis_q          <= '0;
			for (int l = 0; l < MAX_LEVELS; l++) begin
				tx_q[l] <= STRIDE_ONE;
				ty_q[l] <= STRIDE_ONE;
				tz_q[l] <= STRIDE_ONE;
			end
			for (int a = 0; a < 3; a++) begin
				wext_q[a] <= '0;
				strd_q[a] <= STRIDE_ONE;
			end
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (restart) begin
						strides_ready_q <= 1'b0;
					end else if (derive_go) begin
						wext_q[0] <= cfg.ext_x;
						wext_q[1] <= cfg.ext_y;
						wext_q[2] <= cfg.ext_z;
						for (int a = 0; a < 3; a++) begin
							strd_q[a] <= STRIDE_ONE;
						end
						for (int l = 0; l < MAX_LEVELS; l++) begin
							tx_q[l] <= STRIDE_ONE;
							ty_q[l] <= STRIDE_ONE;
							tz_q[l] <= STRIDE_ONE;
						end
						lv_q <= '0;
						d_q  <= '0;
						if (cfg.levels == '0) begin
							strides_ready_q <= 1'b1;
						end else begin
							state_q <= ST_LEVEL;
						end
					end else if (fire && wrap_z) begin
						strides_ready_q <= 1'b0;
					end
				end
				ST_LEVEL: begin
					if (d_q == cfg.splits) begin
						tx_q[lv_q[LVL_IDX_W-1:0]] <= strd_q[0];
						ty_q[lv_q[LVL_IDX_W-1:0]] <= strd_q[1];
						tz_q[lv_q[LVL_IDX_W-1:0]] <= strd_q[2];
						d_q <= '0;
						if (lv_q == cfg.levels - LEVEL_W'(1)) begin
							strides_ready_q <= 1'b1;
							state_q         <= ST_RUN;
						end else begin
							lv_q <= lv_q + LEVEL_W'(1);
						end
					end else begin
						strd_q[axis_pick] <= grown;
						axis_q            <= axis_pick;
						d_q               <= d_q + SPL_W'(1);
						state_q           <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						wext_q[axis_q] <= div_quot;
						state_q        <= ST_LEVEL;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
			cj_q <= '0;
			ck_q <= '0;
			for (int l = 0; l < MAX_LEVELS; l++) begin
				rx_q[l] <= '0;
				ry_q[l] <= '0;
				rz_q[l] <= '0;
			end
		end else if (restart) begin
			ci_q <= '0;
			cj_q <= '0;
			ck_q <= '0;
			for (int l = 0; l < MAX_LEVELS; l++) begin
				rx_q[l] <= '0;
				ry_q[l] <= '0;
				rz_q[l] <= '0;
			end
		end else if (fire) begin
			ci_q <= wrap_x ? '0 : i_inc;
			if (wrap_x) begin
				cj_q <= wrap_y ? '0 : j_inc;
			end
			if (wrap_y) begin
				ck_q <= wrap_z ? '0 : k_inc;
			end
			for (int l = 0; l < MAX_LEVELS; l++) begin
				rx_q[l] <= wrap_x ? '0 : rx_adv[l];
				if (wrap_y) begin
					ry_q[l] <= '0;
				end else if (wrap_x) begin
					ry_q[l] <= ry_adv[l];
				end
				if (wrap_z) begin
					rz_q[l] <= '0;
				end else if (wrap_y) begin
					rz_q[l] <= rz_adv[l];
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/multilevel_strided_volume_decimator_top.sv
// Multilevel strided volume decimator.
// Input channel (in_valid/in_ready, sample_bits): one 32-bit sample word per
// transfer, x fastest, then y, then z, over extent_x * extent_y * extent_z words.
// Output channel (out_valid/out_ready): one word per level that keeps the sample,
// lowest level first, with last_of_run set on the final one for that sample.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six
// registers; a write to any of them starts a new volume. Write only while idle.
// On the first sample of a volume the strides are derived before the sample is
// taken: for each level and each split, one stride grows by the rate and the
// bit-serial divider divides the working extent by the rate, rounding it up.
// After that a sample is taken every cycle while the two-entry queue has room;
// the output side gives one result per cycle while the receiver is ready, so the
// sustained rate is set by the number of results per sample; a sample that no
// level keeps is not queued. A sample reaches the output through the queue, the
// current-word register and output register. Reset sets the registers to their
// defaults, empties the queue and the output register and forces a stride
// derivation on the next sample. When the receiver stalls, the output register
// holds its word, the queue fills and in_ready drops; nothing is lost.
`default_nettype none

module multilevel_strided_volume_decimator_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [msvd_pkg::WORD_W-1:0]     sample_bits,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [msvd_pkg::WORD_W-1:0]          sample_out,
	output logic [msvd_pkg::LEVEL_W-1:0]         level_index,
	output logic                                 last_of_run,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [msvd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [msvd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import msvd_pkg::*;

	logic [EXT_W-1:0]    ext_x_q, ext_y_q, ext_z_q;
	logic [LEVEL_W-1:0]  level_count_q;
	logic [SPL_W-1:0]    splits_q;
	logic [RATE_W-1:0]   rate_q;

	cfg_t      cfg;
	logic      cfg_fire;
	logic      restart;
	logic      front_busy;
	logic      push;
	q_entry_t  push_entry;
	logic      q_full;
	logic      pop;
	q_entry_t  q_head;
	logic      q_empty;

	assign cfg_ready = !front_busy;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign restart   = cfg_fire && (cfg_index <= REG_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_x_q       <= EXT_W'(1);
			ext_y_q       <= EXT_W'(1);
			ext_z_q       <= EXT_W'(1);
			level_count_q <= LEVEL_W'(1);
			splits_q      <= SPL_W'(1);
			rate_q        <= RATE_W'(2);
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_EXT_X:  ext_x_q       <= cfg_data[EXT_W-1:0];
				REG_EXT_Y:  ext_y_q       <= cfg_data[EXT_W-1:0];
				REG_EXT_Z:  ext_z_q       <= cfg_data[EXT_W-1:0];
				REG_LEVELS: level_count_q <= cfg_data[LEVEL_W-1:0];
				REG_SPLITS: splits_q      <= cfg_data[SPL_W-1:0];
				REG_RATE:   rate_q        <= cfg_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.ext_x  = ext_x_q;
		cfg.ext_y  = ext_y_q;
		cfg.ext_z  = ext_z_q;
		cfg.levels = (level_count_q > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS)
			: level_count_q;
		cfg.splits = splits_q;
		cfg.rate   = (rate_q < RATE_W'(2)) ? RATE_W'(2) : rate_q;
	end

	msvd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.restart     (restart),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_bits (sample_bits),
		.push        (push),
		.push_entry  (push_entry),
		.q_full      (q_full),
		.busy        (front_busy)
	);

	msvd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	msvd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.level_index (level_index),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

// File: rtl/core/msvd_chk.sv
`default_nettype none
`include "assert_macros.svh"

module msvd_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [msvd_pkg::WORD_W-1:0] sample_out,
	input wire logic [msvd_pkg::LEVEL_W-1:0] level_index,
	input wire logic                        last_of_run
);
	import msvd_pkg::*;

	logic stalled;
	logic mid_run;

	assign stalled = out_valid && !out_ready;
	assign mid_run = out_valid && out_ready && !last_of_run;

	`MSVD_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(sample_out) && $stable(level_index), "stalled result changed")
	`MSVD_ASSERT_IMP(a_level_range, out_valid, level_index != '0 && level_index <= LEVEL_W'(MAX_LEVELS), "level out of range")
	`MSVD_ASSERT_NXT(a_run_continues, mid_run, out_valid, "run broken before its last word")
	`MSVD_ASSERT_NXT(a_run_ascends, mid_run, level_index > $past(level_index), "levels not ascending within a run")
	`MSVD_ASSERT_NXT(a_run_same_word, mid_run, sample_out == $past(sample_out), "word changed within a run")

endmodule

bind multilevel_strided_volume_decimator_top msvd_chk u_msvd_chk (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import msvd_pkg::*;

	// Indexes past the last register; writes to them change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int RANDOM_SAMPLES = 190;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct {
		logic [WORD_W-1:0]  word;
		logic [LEVEL_W-1:0] level;
		logic               is_last;
	} kept_word_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [WORD_W-1:0]     sample_bits = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [WORD_W-1:0]     sample_out;
	logic [LEVEL_W-1:0]    level_index;
	logic                  last_of_run;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// Local copy of the registers and the stride state of the block.
	logic [EXT_W-1:0]   ext_reg [3];
	logic [LEVEL_W-1:0] levels_reg;
	logic [SPL_W-1:0]   splits_reg;
	logic [RATE_W-1:0]  rate_reg;
	int unsigned        stride_tab [3][MAX_LEVELS];
	logic [EXT_W-1:0]   coord [3];
	bit                 strides_valid;

	kept_word_t kept_q [$];
	int mismatch_count = 0;
	int words_checked  = 0;
	int samples_sent   = 0;
	int settings_used  = 0;
	int burst_left     = 0;
	bit tx_quiet       = 1'b0;
	bit rx_quiet       = 1'b0;
	int rx_hold        = 0;

	multilevel_strided_volume_decimator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_bits(sample_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.level_index(level_index),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned active_levels();
		return (levels_reg > MAX_LEVELS) ? MAX_LEVELS : levels_reg;
	endfunction

	function automatic void restart_volume();
		int a;
		strides_valid = 1'b0;
		for (a = 0; a < 3; a++)
			coord[a] = '0;
	endfunction

	function automatic void mirror_reg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_EXT_X: ext_reg[0] = data[EXT_W-1:0];
			REG_EXT_Y: ext_reg[1] = data[EXT_W-1:0];
			REG_EXT_Z: ext_reg[2] = data[EXT_W-1:0];
			REG_LEVELS: levels_reg = data[LEVEL_W-1:0];
			REG_SPLITS: splits_reg = data[SPL_W-1:0];
			REG_RATE: rate_reg = data[RATE_W-1:0];
			default: return;
		endcase
		restart_volume();
	endfunction

	// Each split grows the stride of the axis with the largest remaining extent
	// (z wins ties, then y) and divides that extent by the rate, rounding up.
	function automatic void derive_level_strides();
		int unsigned rate, nlev, ax, grown, lv, d, a;
		int unsigned span [3];
		int unsigned cur [3];
		rate = (rate_reg < 2) ? 2 : rate_reg;
		nlev = active_levels();
		for (a = 0; a < 3; a++) begin
			span[a] = ext_reg[a];
			cur[a] = 1;
			for (lv = 0; lv < MAX_LEVELS; lv++)
				stride_tab[a][lv] = 1;
		end
		for (lv = 0; lv < nlev; lv++) begin
			for (d = 0; d < splits_reg; d++) begin
				if (span[2] >= span[1] && span[2] >= span[0])
					ax = 2;
				else if (span[1] >= span[0])
					ax = 1;
				else
					ax = 0;
				grown = cur[ax] * rate;
				cur[ax] = (grown > STRIDE_CAP) ? STRIDE_CAP : grown;
				span[ax] = (span[ax] + rate - 1) / rate;
			end
			for (a = 0; a < 3; a++)
				stride_tab[a][lv] = cur[a];
		end
		strides_valid = 1'b1;
	endfunction

	function automatic void predict_kept_words(input logic [WORD_W-1:0] word);
		logic [MAX_LEVELS-1:0] keep;
		int unsigned nlev, top, lv;
		kept_word_t kw;
		if (!strides_valid)
			derive_level_strides();
		nlev = active_levels();
		keep = '0;
		top = 0;
		for (lv = 0; lv < nlev; lv++) begin
			if (coord[0] % stride_tab[0][lv] == 0 && coord[1] % stride_tab[1][lv] == 0 &&
					coord[2] % stride_tab[2][lv] == 0) begin
				keep[lv] = 1'b1;
				top = lv;
			end
		end
		for (lv = 0; lv < nlev; lv++) begin
			if (keep[lv]) begin
				kw.word = word;
				kw.level = LEVEL_W'(lv + 1);
				kw.is_last = (lv == top);
				kept_q.push_back(kw);
			end
		end
		// An extent of zero wraps the 16-bit counter back to zero, i.e. 65536 steps.
		coord[0] = coord[0] + 1'b1;
		if (coord[0] == ext_reg[0]) begin
			coord[0] = '0;
			coord[1] = coord[1] + 1'b1;
			if (coord[1] == ext_reg[1]) begin
				coord[1] = '0;
				coord[2] = coord[2] + 1'b1;
				if (coord[2] == ext_reg[2]) begin
					coord[2] = '0;
					strides_valid = 1'b0;
				end
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
		input logic [WORD_W-1:0] want);
		mismatch_count++;
		$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
	endtask

	task automatic send_sample(input logic [WORD_W-1:0] word);
		if (burst_left == 0) begin
			if (!tx_quiet) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		sample_bits <= word;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		samples_sent++;
		predict_kept_words(word);
	endtask

	// Leaves cfg_valid high so that writes can follow back to back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		mirror_reg_write(idx, data);
	endtask

	task automatic write_regs(input bit [5:0] sel, input logic [CFG_DATA_W-1:0] v0, v1, v2,
		v3, v4, v5);
		logic [CFG_DATA_W-1:0] vals [6];
		logic [CFG_IDX_W-1:0] idx [6];
		int r;
		vals = '{v0, v1, v2, v3, v4, v5};
		idx = '{REG_EXT_X, REG_EXT_Y, REG_EXT_Z, REG_LEVELS, REG_SPLITS, REG_RATE};
		for (r = 0; r < 6; r++)
			if (sel[r])
				write_reg(idx[r], vals[r]);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// A sample kept by no level gives no word, so the task keeps waiting after the
	// last expected word before the block counts as idle.
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		while (kept_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_default_registers();
		send_sample('0);
		send_sample('1);
		wait_until_idle();
	endtask

	task automatic test_all_levels();
		write_regs(6'h3F, 16'd4, 16'd2, 16'd2, 16'(MAX_LEVELS), 16'd1, 16'd2);
		send_sample(32'hAAAA_AAAA);
		send_sample(32'h5555_5555);
		repeat (3) send_sample($urandom);
		wait_until_idle();
	endtask

	task automatic test_volume_end();
		write_regs(6'h3F, 16'd2, 16'd1, 16'd1, 16'd1, 16'd0, 16'd2);
		repeat (3) send_sample($urandom);
		wait_until_idle();
	endtask

	task automatic test_spare_index();
		write_regs(6'h3F, 16'd3, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
		send_sample($urandom);
		wait_until_idle();
		// The volume must carry on at x = 1 after these writes.
		write_reg(REG_SPARE_LO, $urandom_range(0, 65535));
		write_reg(REG_SPARE_HI, $urandom_range(0, 65535));
		cfg_valid <= 1'b0;
		repeat (2) send_sample($urandom);
		wait_until_idle();
	endtask

	task automatic test_register_corners();
		write_regs(6'h3F, 16'd2, 16'd2, 16'd1, 16'd0, 16'd1, 16'd2);
		repeat (2) send_sample($urandom);
		wait_until_idle();
		write_regs(6'h3F, 16'd0, 16'hFFFF, 16'd1, 16'd15, 16'd7, 16'd0);
		repeat (2) send_sample($urandom);
		wait_until_idle();
		// Upper data bits beyond each register's width are dropped.
		write_regs(6'h3F, 16'hFFFF, 16'd5, 16'd0, 16'hFFF9, 16'hFFFC, 16'hFFE1);
		send_sample($urandom);
		wait_until_idle();
		write_regs(6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd8, 16'd4, 16'd16);
		send_sample($urandom);
		wait_until_idle();
		write_regs(6'h3F, 16'd7, 16'd3, 16'd9, 16'd8, 16'd7, 16'h001F);
		send_sample($urandom);
		wait_until_idle();
	endtask

	task automatic test_random_volumes();
		logic [CFG_DATA_W-1:0] v [6];
		bit [5:0] sel;
		longint vol;
		int start, n, kind, a, remaining;
		start = samples_sent;
		while (samples_sent - start < RANDOM_SAMPLES) begin
			kind = $urandom_range(0, 9);
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet <= ($urandom_range(0, 4) == 0);
			if (kind == 0) begin
				for (a = 0; a < 3; a++)
					case ($urandom_range(0, 2))
						0: v[a] = '0;
						1: v[a] = '1;
						default: v[a] = $urandom_range(1, 65535);
					endcase
				for (a = 3; a < 6; a++)
					v[a] = $urandom_range(0, 65535);
			end else begin
				v[0] = $urandom_range(1, 4);
				v[1] = $urandom_range(1, 4);
				v[2] = $urandom_range(1, 3);
				v[3] = $urandom_range(1, 4);
				v[4] = $urandom_range(0, 3);
				v[5] = $urandom_range(2, 4);
			end
			sel = (kind == 1) ? 6'($urandom_range(0, 63)) : 6'h3F;
			write_regs(sel, v[0], v[1], v[2], v[3], v[4], v[5]);
			vol = 1;
			for (a = 0; a < 3; a++)
				vol = vol * ((ext_reg[a] == 0) ? 65536 : ext_reg[a]);
			// Mostly whole volumes; now and then one cut short.
			if (vol <= 64) begin
				n = int'(vol) * $urandom_range(1, 2);
				if ($urandom_range(0, 3) == 0)
					n = n + $urandom_range(1, int'(vol));
			end else begin
				n = $urandom_range(1, 8);
			end
			remaining = RANDOM_SAMPLES - (samples_sent - start);
			if (n > remaining)
				n = remaining;
			repeat (n) send_sample($urandom);
			wait_until_idle();
		end
	endtask

	always @(posedge clk) begin
		if (rx_quiet) begin
			out_ready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			out_ready <= !out_ready;
			rx_hold <= out_ready ? $urandom_range(0, 4) : $urandom_range(0, 15);
		end
	end

	always @(posedge clk) begin : check_words
		kept_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (kept_q.size() == 0) begin
				report_mismatch("unexpected word", sample_out, '0);
			end else begin
				want = kept_q.pop_front();
				words_checked++;
				if (sample_out !== want.word)
					report_mismatch("sample_out", sample_out, want.word);
				if (level_index !== want.level)
					report_mismatch("level_index", WORD_W'(level_index), WORD_W'(want.level));
				if (last_of_run !== want.is_last)
					report_mismatch("last_of_run", WORD_W'(last_of_run), WORD_W'(want.is_last));
			end
		end
	end

	initial begin
		ext_reg = '{16'd1, 16'd1, 16'd1};
		levels_reg = 4'd1;
		splits_reg = 3'd1;
		rate_reg = 5'd2;
		restart_volume();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_registers();
		test_all_levels();
		test_volume_end();
		test_spare_index();
		test_register_corners();
		test_random_volumes();
		wait_until_idle();
		$display("Sent %0d samples over %0d register settings; %0d kept words checked.",
			samples_sent, settings_used, words_checked);
		$display("Mismatches found: %0d.", mismatch_count);
		if (mismatch_count == 0 && kept_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d kept words still expected.", kept_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
